// File: rtl/core/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// shared constants, codes and control types of the text console writer
// ----------------------------------------------------------------------------
package tcw_pkg;

	// screen geometry
	localparam int ROW_COUNT  = 25;
	localparam int COL_COUNT  = 80;
	localparam int CELL_TOTAL = ROW_COUNT * COL_COUNT;

	localparam int ROW_W  = $clog2(ROW_COUNT);
	localparam int COL_W  = $clog2(COL_COUNT);
	localparam int CELL_W = $clog2(CELL_TOTAL);

	// cell contents
	localparam logic [7:0] BLANK_CHAR = 8'h20;
	localparam logic [7:0] PLAIN_ATTR = 8'h07;
	localparam logic [7:0] ERASE_ATTR = 8'h03;

	// operation codes
	typedef enum logic [2:0] {
		FN_PUT       = 3'd0,
		FN_NEWLINE   = 3'd1,
		FN_BACKSPACE = 3'd2,
		FN_CLEAR     = 3'd3,
		FN_READ      = 3'd4
	} func_t;

	// controller states
	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_EXEC,
		ST_SCR_RD,
		ST_SCR_WR,
		ST_FILL
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic exec;
		logic scr_rd;
		logic scr_wr;
		logic fill;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic go_scroll;
		logic go_clear;
		logic copy_last;
		logic fill_last;
	} dp_status_t;

endpackage

// File: rtl/core/tcw_ctrl.sv
// ----------------------------------------------------------------------------
// tcw_ctrl
// sequencer: reset clearing pass, single-beat operations, scroll and clear
// ----------------------------------------------------------------------------
module tcw_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	output logic               done,
	output tcw_pkg::dp_cmd_t   cmd,
	input  tcw_pkg::dp_status_t status
);
	import tcw_pkg::*;

	state_t state_q;
	state_t state_nxt;
	logic   finish;
	logic   done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			done_q  <= finish;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_INIT: begin
				if (status.fill_last) state_nxt = ST_IDLE;
			end
			ST_IDLE: begin
				if (start) state_nxt = ST_EXEC;
			end
			ST_EXEC: begin
				if (status.go_scroll)     state_nxt = ST_SCR_RD;
				else if (status.go_clear) state_nxt = ST_FILL;
				else                      state_nxt = ST_IDLE;
			end
			ST_SCR_RD: state_nxt = ST_SCR_WR;
			ST_SCR_WR: begin
				state_nxt = status.copy_last ? ST_FILL : ST_SCR_RD;
			end
			ST_FILL: begin
				if (status.fill_last) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_INIT;
		endcase
	end

	// outputs
	always_comb begin
		cmd.load   = (state_q == ST_IDLE) && start;
		cmd.exec   = (state_q == ST_EXEC);
		cmd.scr_rd = (state_q == ST_SCR_RD);
		cmd.scr_wr = (state_q == ST_SCR_WR);
		cmd.fill   = (state_q == ST_FILL) || (state_q == ST_INIT);
		finish     = ((state_q == ST_EXEC) && !status.go_scroll && !status.go_clear) ||
		             ((state_q == ST_FILL) && status.fill_last);
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;

endmodule

// File: rtl/core/tcw_datapath.sv
// ----------------------------------------------------------------------------
// tcw_datapath
// screen store, cursor registers, sweep pointer and result registers
// ----------------------------------------------------------------------------
module tcw_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  tcw_pkg::dp_cmd_t    cmd,
	output tcw_pkg::dp_status_t status,
	input  logic [2:0]          func,
	input  logic [7:0]          ch,
	input  logic [7:0]          color,
	input  logic [10:0]         cell_index,
	output logic [7:0]          cell_char,
	output logic [7:0]          cell_attr,
	output logic [4:0]          cursor_row,
	output logic [6:0]          cursor_col,
	output logic [10:0]         cursor_linear
);
	import tcw_pkg::*;

	// latched beat
	logic [2:0]        func_q;
	logic [7:0]        ch_q;
	logic [7:0]        color_q;
	logic [10:0]       idx_q;

	logic [ROW_W-1:0]  row_q;
	logic [COL_W-1:0]  col_q;
	logic [CELL_W-1:0] ptr_q;
	logic              rd_ok_q;

	logic [15:0]       mem [CELL_TOTAL];
	logic [15:0]       rd_q;

	logic              col_last;
	logic              idx_ok;
	logic [ROW_W-1:0]  bs_row;
	logic [COL_W-1:0]  bs_col;
	logic [ROW_W-1:0]  tgt_row;
	logic [COL_W-1:0]  tgt_col;
	logic [CELL_W-1:0] tgt_pos;
	logic [CELL_W-1:0] cur_pos;
	logic [31:0]       row_ext;
	logic [31:0]       col_ext;
	logic [31:0]       pos_ext;

	logic              we;
	logic [CELL_W-1:0] waddr;
	logic [15:0]       wdata;
	logic              re;
	logic [CELL_W-1:0] raddr;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q  <= func;
			ch_q    <= ch;
			color_q <= color;
			idx_q   <= cell_index;
		end
	end

	assign col_last = (col_q == COL_W'(COL_COUNT - 1));
	assign idx_ok   = (32'(idx_q) < 32'(CELL_TOTAL));

	// backspace target, row held at the top
	always_comb begin
		if (col_q == '0) begin
			bs_col = COL_W'(COL_COUNT - 1);
			bs_row = (row_q == '0) ? '0 : row_q - 1'b1;
		end else begin
			bs_col = col_q - 1'b1;
			bs_row = row_q;
		end
	end

	assign tgt_row = (func_q == FN_BACKSPACE) ? bs_row : row_q;
	assign tgt_col = (func_q == FN_BACKSPACE) ? bs_col : col_q;
	assign tgt_pos = CELL_W'(tgt_row) * CELL_W'(COL_COUNT) + CELL_W'(tgt_col);
	assign cur_pos = CELL_W'(row_q) * CELL_W'(COL_COUNT) + CELL_W'(col_q);

	// cursor and sweep pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q   <= ROW_W'(ROW_COUNT - 1);
			col_q   <= '0;
			ptr_q   <= '0;
			rd_ok_q <= 1'b0;
		end else begin
			if (cmd.exec) begin
				ptr_q   <= '0;
				rd_ok_q <= (func_q == FN_READ) && idx_ok;
				case (func_q)
					FN_PUT:       col_q <= col_last ? '0 : col_q + 1'b1;
					FN_NEWLINE:   col_q <= '0;
					FN_BACKSPACE: begin
						row_q <= bs_row;
						col_q <= bs_col;
					end
					default: ;
				endcase
			end else if (cmd.scr_wr || cmd.fill) begin
				ptr_q <= ptr_q + 1'b1;
			end
		end
	end

	// store port selection
	always_comb begin
		we    = 1'b0;
		waddr = tgt_pos;
		wdata = {PLAIN_ATTR, BLANK_CHAR};
		if (cmd.exec && (func_q == FN_PUT)) begin
			we    = 1'b1;
			wdata = {color_q, ch_q};
		end else if (cmd.exec && (func_q == FN_BACKSPACE)) begin
			we    = 1'b1;
			wdata = {ERASE_ATTR, BLANK_CHAR};
		end else if (cmd.scr_wr) begin
			we    = 1'b1;
			waddr = ptr_q;
			wdata = rd_q;
		end else if (cmd.fill) begin
			we    = 1'b1;
			waddr = ptr_q;
		end
	end

	always_comb begin
		re    = 1'b0;
		raddr = CELL_W'(idx_q);
		if (cmd.exec && (func_q == FN_READ) && idx_ok) begin
			re = 1'b1;
		end else if (cmd.scr_rd) begin
			re    = 1'b1;
			raddr = ptr_q + CELL_W'(COL_COUNT);
		end
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (re) rd_q <= mem[raddr];
	end

	assign status.go_scroll = (func_q == FN_NEWLINE) || ((func_q == FN_PUT) && col_last);
	assign status.go_clear  = (func_q == FN_CLEAR);
	assign status.copy_last = (ptr_q == CELL_W'(CELL_TOTAL - COL_COUNT - 1));
	assign status.fill_last = (ptr_q == CELL_W'(CELL_TOTAL - 1));

	// result fields
	assign row_ext = 32'(row_q);
	assign col_ext = 32'(col_q);
	assign pos_ext = 32'(cur_pos);

	assign cell_char     = rd_ok_q ? rd_q[7:0]  : 8'h00;
	assign cell_attr     = rd_ok_q ? rd_q[15:8] : 8'h00;
	assign cursor_row    = row_ext[4:0];
	assign cursor_col    = col_ext[6:0];
	assign cursor_linear = pos_ext[10:0];

endmodule

// File: rtl/core/text_console_writer.sv
// ----------------------------------------------------------------------------
// text_console_writer
// A text-mode screen store of character and attribute cells with a cursor.
// Issue an operation by raising start while busy is low; the beat is taken at
// that edge. Every operation returns exactly one result beat, shown for a
// single cycle with done high, which cannot be held off, so sample it then.
// The cursor outputs always show the current cursor. Put char, backspace,
// read and the unused codes go from the execute state straight back to idle.
// A newline, or a put char on the last column, scrolls: the store copies
// each cell one row up with a read then a write, then blanks the bottom row,
// and only after that is the next beat taken. Clear writes one cell a cycle.
// After reset a clearing pass fills the store with blanks while busy stays
// high.
// ----------------------------------------------------------------------------
module text_console_writer (
	input  logic        clk,
	input  logic        arst_n,
	// command beat
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  func,
	input  logic [7:0]  ch,
	input  logic [7:0]  color,
	input  logic [10:0] cell_index,
	// result beat
	output logic        done,
	output logic [7:0]  cell_char,
	output logic [7:0]  cell_attr,
	output logic [4:0]  cursor_row,
	output logic [6:0]  cursor_col,
	output logic [10:0] cursor_linear
);
	import tcw_pkg::*;

	// command and status between sequencer and datapath
	dp_cmd_t    cmd;
	dp_status_t status;

	// sequencer: owns busy and the done strobe
	tcw_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd),
		.status (status)
	);

	// datapath: store, cursor and result fields
	tcw_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.func          (func),
		.ch            (ch),
		.color         (color),
		.cell_index    (cell_index),
		.cell_char     (cell_char),
		.cell_attr     (cell_attr),
		.cursor_row    (cursor_row),
		.cursor_col    (cursor_col),
		.cursor_linear (cursor_linear)
	);

	// a result beat only appears once the sequencer is back in idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result beat while busy");

	// an accepted beat always makes the block busy for the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted beat did not start work");

	// a read returns its result beat straight after the execute state
	a_read_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (func == FN_READ)) |-> ##2 done)
		else $error("read result missing");

	// the cursor never leaves the screen
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(cursor_col) < 32'(COL_COUNT)) && (32'(cursor_row) < 32'(ROW_COUNT)))
		else $error("cursor outside the screen");

endmodule
